>>> rtl/bwlc_pkg.sv
// Package for the battery warning-level controller: item types, configuration
// register set, level, action and register index codes.
// No dependencies.
`default_nettype none

package bwlc_pkg;

   localparam int unsigned QUEUE_DEPTH_DEF = 2;
   localparam int unsigned RSP_DEPTH_DEF   = 2;

   localparam int unsigned CHG_W  = 14;
   localparam int unsigned SEC_W  = 32;
   localparam int unsigned PCT_W  = 7;
   localparam int unsigned LVL_W  = 3;
   localparam int unsigned ACT_W  = 3;
   localparam int unsigned TICK_W = 3;
   localparam int unsigned IDX_W  = 4;
   localparam int unsigned CSR_W  = 32;

   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   localparam logic [LVL_W-1:0] LVL_NONE     = 3'd0;
   localparam logic [LVL_W-1:0] LVL_REMIND   = 3'd1;
   localparam logic [LVL_W-1:0] LVL_LOW      = 3'd2;
   localparam logic [LVL_W-1:0] LVL_DANGER   = 3'd3;
   localparam logic [LVL_W-1:0] LVL_CRITICAL = 3'd4;
   localparam logic [LVL_W-1:0] LVL_ACTION   = 3'd5;

   localparam logic [ACT_W-1:0] ACT_NONE      = 3'd0;
   localparam logic [ACT_W-1:0] ACT_LOCK      = 3'd1;
   localparam logic [ACT_W-1:0] ACT_SHOW      = 3'd2;
   localparam logic [ACT_W-1:0] ACT_SUSPEND   = 3'd3;
   localparam logic [ACT_W-1:0] ACT_HIBERNATE = 3'd4;

   localparam logic [TICK_W-1:0] TICK_LOCK    = 3'd3;
   localparam logic [TICK_W-1:0] TICK_SHOW    = 3'd4;
   localparam logic [TICK_W-1:0] TICK_SUSPEND = 3'd5;

   // charge limits in hundredths of a percent
   localparam logic [CHG_W-1:0] PCT_SCALE      = 14'd100;
   localparam logic [CHG_W-1:0] CHG_CRITICAL   = 14'd1000;
   localparam logic [CHG_W-1:0] CHG_DANGER     = 14'd1500;
   localparam logic [CHG_W-1:0] CHG_LOW        = 14'd2000;
   localparam logic [CHG_W-1:0] CHG_REMIND     = 14'd2500;

   localparam logic [IDX_W-1:0] CSR_USE_PERCENTAGE   = 4'd0;
   localparam logic [IDX_W-1:0] CSR_NOTIFY_THRESHOLD = 4'd1;
   localparam logic [IDX_W-1:0] CSR_ACTION_PERCENT   = 4'd2;
   localparam logic [IDX_W-1:0] CSR_LOW_SECONDS      = 4'd3;
   localparam logic [IDX_W-1:0] CSR_DANGER_SECONDS   = 4'd4;
   localparam logic [IDX_W-1:0] CSR_CRITICAL_SECONDS = 4'd5;
   localparam logic [IDX_W-1:0] CSR_ACTION_SECONDS   = 4'd6;
   localparam logic [IDX_W-1:0] CSR_ACTION_MODE      = 4'd7;

   typedef struct packed {
      logic             command;
      logic             on_battery;
      logic [CHG_W-1:0] charge_hundredths;
      logic [SEC_W-1:0] time_to_empty;
   } req_type;

   typedef struct packed {
      logic [LVL_W-1:0] warn_level;
      logic             level_changed;
      logic [ACT_W-1:0] action;
   } rsp_type;

   typedef struct packed {
      logic             use_percentage;
      logic [PCT_W-1:0] notify_threshold;
      logic [PCT_W-1:0] action_percent;
      logic [SEC_W-1:0] low_seconds;
      logic [SEC_W-1:0] danger_seconds;
      logic [SEC_W-1:0] critical_seconds;
      logic [SEC_W-1:0] action_seconds;
      logic [1:0]       action_mode;
   } cfg_type;

   // classified item handed from front to back
   typedef struct packed {
      logic             command;
      logic             on_battery;
      logic             zero_hold;
      logic [LVL_W-1:0] level;
   } cls_type;

endpackage

`default_nettype wire

>>> rtl/bwlc_csr.sv
// Configuration register file of the battery warning-level controller.
// Depends on bwlc_pkg.
`default_nettype none

module bwlc_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [bwlc_pkg::IDX_W-1:0]  csr_index,
   input  wire logic [bwlc_pkg::CSR_W-1:0]  csr_data,
   output bwlc_pkg::cfg_type                cfg
);

   bwlc_pkg::cfg_type cfg_ff;
   bwlc_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            bwlc_pkg::CSR_USE_PERCENTAGE: begin
               cfg_in.use_percentage = csr_data[0];
            end
            bwlc_pkg::CSR_NOTIFY_THRESHOLD: begin
               cfg_in.notify_threshold = csr_data[bwlc_pkg::PCT_W-1:0];
            end
            bwlc_pkg::CSR_ACTION_PERCENT: begin
               cfg_in.action_percent = csr_data[bwlc_pkg::PCT_W-1:0];
            end
            bwlc_pkg::CSR_LOW_SECONDS: begin
               cfg_in.low_seconds = csr_data[bwlc_pkg::SEC_W-1:0];
            end
            bwlc_pkg::CSR_DANGER_SECONDS: begin
               cfg_in.danger_seconds = csr_data[bwlc_pkg::SEC_W-1:0];
            end
            bwlc_pkg::CSR_CRITICAL_SECONDS: begin
               cfg_in.critical_seconds = csr_data[bwlc_pkg::SEC_W-1:0];
            end
            bwlc_pkg::CSR_ACTION_SECONDS: begin
               cfg_in.action_seconds = csr_data[bwlc_pkg::SEC_W-1:0];
            end
            bwlc_pkg::CSR_ACTION_MODE: begin
               cfg_in.action_mode = csr_data[1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{use_percentage: 1'b1, default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/bwlc_fifo.sv
// Small register-based queue used between the stages and at the output.
// No dependencies.
`default_nettype none

module bwlc_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> rtl/bwlc_front.sv
// Front stage: accepts input items and classifies status updates into a level.
// Depends on bwlc_pkg.
`default_nettype none

module bwlc_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire bwlc_pkg::req_type req_data,
   input  wire bwlc_pkg::cfg_type cfg,
   input  wire logic              q_full,
   output logic                   q_push,
   output bwlc_pkg::cls_type      q_data
);

   logic                           valid_ff, valid_in;
   bwlc_pkg::cls_type              item_ff, item_in;
   bwlc_pkg::cls_type              cls;
   logic                           accept;
   logic [bwlc_pkg::CHG_W-1:0]     notify_lim;
   logic [bwlc_pkg::CHG_W-1:0]     action_lim;
   logic [bwlc_pkg::LVL_W-1:0]     pct_level;
   logic [bwlc_pkg::LVL_W-1:0]     time_level;
   logic [bwlc_pkg::CHG_W-1:0]     chg;
   logic [bwlc_pkg::SEC_W-1:0]     tte;

   assign chg        = req_data.charge_hundredths;
   assign tte        = req_data.time_to_empty;
   assign notify_lim = bwlc_pkg::CHG_W'(cfg.notify_threshold) * bwlc_pkg::PCT_SCALE;
   assign action_lim = bwlc_pkg::CHG_W'(cfg.action_percent) * bwlc_pkg::PCT_SCALE;

   always_comb begin
      priority if (chg == '0 || chg > notify_lim) begin
         pct_level = bwlc_pkg::LVL_NONE;
      end else if (cfg.action_percent != '0 && chg <= action_lim) begin
         pct_level = bwlc_pkg::LVL_ACTION;
      end else if (chg <= bwlc_pkg::CHG_CRITICAL) begin
         pct_level = bwlc_pkg::LVL_CRITICAL;
      end else if (chg <= bwlc_pkg::CHG_DANGER) begin
         pct_level = bwlc_pkg::LVL_DANGER;
      end else if (chg <= bwlc_pkg::CHG_LOW) begin
         pct_level = bwlc_pkg::LVL_LOW;
      end else if (chg <= bwlc_pkg::CHG_REMIND) begin
         pct_level = bwlc_pkg::LVL_REMIND;
      end else begin
         pct_level = bwlc_pkg::LVL_NONE;
      end
   end

   always_comb begin
      priority if (tte == '0 || tte > cfg.low_seconds) begin
         time_level = bwlc_pkg::LVL_NONE;
      end else if (tte > cfg.danger_seconds) begin
         time_level = bwlc_pkg::LVL_LOW;
      end else if (tte > cfg.critical_seconds) begin
         time_level = bwlc_pkg::LVL_DANGER;
      end else if (tte > cfg.action_seconds) begin
         time_level = bwlc_pkg::LVL_CRITICAL;
      end else begin
         time_level = bwlc_pkg::LVL_ACTION;
      end
   end

   always_comb begin
      cls.command    = req_data.command;
      cls.on_battery = req_data.on_battery;
      cls.zero_hold  = cfg.use_percentage && (chg == '0);
      cls.level      = cfg.use_percentage ? pct_level : time_level;
   end

   assign full   = valid_ff && q_full;
   assign accept = push && !full;
   assign q_push = valid_ff;
   assign q_data = item_ff;

   assign valid_in = accept || (valid_ff && q_full);
   assign item_in  = accept ? cls : item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

`default_nettype wire

>>> rtl/bwlc_back.sv
// Back stage: holds the warning level and action countdown, applies each
// classified item and produces its result item. Depends on bwlc_pkg.
`default_nettype none

module bwlc_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [1:0]        action_mode,
   input  wire logic              q_empty,
   input  wire bwlc_pkg::cls_type q_data,
   output logic                   q_pop,
   input  wire logic              out_full,
   output logic                   out_push,
   output bwlc_pkg::rsp_type      out_data
);

   logic [bwlc_pkg::LVL_W-1:0]  level_ff, level_in;
   logic                        running_ff, running_in;
   logic [bwlc_pkg::TICK_W-1:0] tick_ff, tick_in;
   logic [bwlc_pkg::TICK_W-1:0] tick_next;
   logic                        changed;
   logic [bwlc_pkg::ACT_W-1:0]  action;

   assign q_pop     = !q_empty && !out_full;
   assign out_push  = q_pop;
   assign tick_next = tick_ff + 1'b1;

   always_comb begin
      level_in   = level_ff;
      running_in = running_ff;
      tick_in    = tick_ff;
      changed    = 1'b0;
      action     = bwlc_pkg::ACT_NONE;
      if (q_pop) begin
         if (q_data.command == bwlc_pkg::CMD_UPDATE) begin
            if (!q_data.on_battery) begin
               running_in = 1'b0;
               if (level_ff != bwlc_pkg::LVL_NONE) begin
                  level_in = bwlc_pkg::LVL_NONE;
                  changed  = 1'b1;
               end
            end else if (!(q_data.zero_hold && level_ff != bwlc_pkg::LVL_NONE)) begin
               if (q_data.level != level_ff) begin
                  level_in   = q_data.level;
                  changed    = 1'b1;
                  running_in = (q_data.level == bwlc_pkg::LVL_ACTION);
                  if (q_data.level == bwlc_pkg::LVL_ACTION) begin
                     tick_in = '0;
                  end
               end
            end
         end else if (running_ff) begin
            tick_in = tick_next;
            priority if (tick_next == bwlc_pkg::TICK_LOCK) begin
               action = action_mode[1] ? bwlc_pkg::ACT_LOCK : bwlc_pkg::ACT_NONE;
            end else if (tick_next == bwlc_pkg::TICK_SHOW) begin
               action = bwlc_pkg::ACT_SHOW;
            end else if (tick_next >= bwlc_pkg::TICK_SUSPEND) begin
               running_in = 1'b0;
               action = action_mode[0] ? bwlc_pkg::ACT_HIBERNATE : bwlc_pkg::ACT_SUSPEND;
            end else begin
               action = bwlc_pkg::ACT_NONE;
            end
         end
      end
   end

   always_comb begin
      out_data.warn_level    = level_in;
      out_data.level_changed = changed;
      out_data.action        = action;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff   <= bwlc_pkg::LVL_NONE;
         running_ff <= 1'b0;
         tick_ff    <= '0;
      end else begin
         level_ff   <= level_in;
         running_ff <= running_in;
         tick_ff    <= tick_in;
      end
   end

`ifndef SYNTHESIS
   a_running_at_action: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> level_ff == bwlc_pkg::LVL_ACTION)
      else $error("countdown running below Action level");

   a_tick_bound: assert property (@(posedge clock) disable iff (reset)
      tick_ff <= bwlc_pkg::TICK_SUSPEND)
      else $error("tick count past suspend");

   a_action_on_tick: assert property (@(posedge clock) disable iff (reset)
      (out_push && out_data.action != bwlc_pkg::ACT_NONE)
         |-> (q_data.command == bwlc_pkg::CMD_TICK && running_ff))
      else $error("action without a running countdown tick");

   a_change_moves_level: assert property (@(posedge clock) disable iff (reset)
      (out_push && out_data.level_changed) |=> level_ff != $past(level_ff))
      else $error("level flagged as changed but held");
`endif

endmodule

`default_nettype wire

>>> rtl/battery_warn_level_controller_top.sv
// Battery warning-level controller, top level.
// A result reaches the rsp ports after its item is accepted and has passed the
// front register, classified-item queue and back stage into the result queue.
// Throughput: one item per cycle, set by the back stage, while rsp has room.
// Reset: synchronous, active high; level None, countdown stopped, registers
// at their reset values, both queues empty.
`default_nettype none

module battery_warn_level_controller_top #(
   parameter int unsigned QUEUE_DEPTH = bwlc_pkg::QUEUE_DEPTH_DEF,
   parameter int unsigned RSP_DEPTH   = bwlc_pkg::RSP_DEPTH_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   output logic                             full,
   input  wire bwlc_pkg::req_type           req_data,
   output logic                             empty,
   input  wire logic                        pop,
   output bwlc_pkg::rsp_type                rsp_data,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [bwlc_pkg::IDX_W-1:0]  csr_index,
   input  wire logic [bwlc_pkg::CSR_W-1:0]  csr_data
);

   bwlc_pkg::cfg_type cfg;
   bwlc_pkg::cls_type fq_push_data, fq_pop_data;
   bwlc_pkg::rsp_type rq_push_data;
   logic              fq_push, fq_full, fq_pop, fq_empty;
   logic              rq_push, rq_full;

   bwlc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bwlc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .cfg      (cfg),
      .q_full   (fq_full),
      .q_push   (fq_push),
      .q_data   (fq_push_data)
   );

   bwlc_fifo #(
      .WIDTH ($bits(bwlc_pkg::cls_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_cls_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .push_data (fq_push_data),
      .full      (fq_full),
      .pop       (fq_pop),
      .pop_data  (fq_pop_data),
      .empty     (fq_empty)
   );

   bwlc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .action_mode (cfg.action_mode),
      .q_empty     (fq_empty),
      .q_data      (fq_pop_data),
      .q_pop       (fq_pop),
      .out_full    (rq_full),
      .out_push    (rq_push),
      .out_data    (rq_push_data)
   );

   bwlc_fifo #(
      .WIDTH ($bits(bwlc_pkg::rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rq_push),
      .push_data (rq_push_data),
      .full      (rq_full),
      .pop       (pop),
      .pop_data  (rsp_data),
      .empty     (empty)
   );

endmodule

`default_nettype wire
